// ----- rtl/key_mouse_input_tracker_core_macros.svh -----
`ifndef KEY_MOUSE_INPUT_TRACKER_CORE_MACROS_SVH
`define KEY_MOUSE_INPUT_TRACKER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define KMIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define KMIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kmit_pkg.sv -----
package kmit_pkg;

  localparam int NUM_KEYS_DEF    = 32;
  localparam int NUM_BUTTONS_DEF = 8;

  localparam int FUNC_W  = 3;
  localparam int KEY_W   = 5;
  localparam int BTN_W   = 3;
  localparam int POS_W   = 16;
  localparam int TIMER_W = 16;
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 5;
  localparam int DELTA_W = 17;
  localparam int FLAGS_W = 3;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic [FUNC_W-1:0] FN_TICK    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_KPRESS  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_KREL    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MOVE    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_BPRESS  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_BREL    = 3'd5;
  localparam logic [FUNC_W-1:0] FN_WHEEL   = 3'd6;

  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAG   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLICK  = 2'd3;

  localparam logic [1:0] REG_REPEAT_ENABLE = 2'd0;
  localparam logic [1:0] REG_REPEAT_DELAY  = 2'd1;
  localparam logic [1:0] REG_CLICK_MAX     = 2'd2;

  localparam logic [TIMER_W-1:0] REPEAT_DELAY_RST = 16'd500;
  localparam logic [TIMER_W-1:0] CLICK_MAX_RST    = 16'd250;

  localparam int MAX_REPEATS = 32;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [INDEX_W-1:0]      index;
    logic signed [POS_W-1:0] begin_x;
    logic signed [POS_W-1:0] begin_y;
    logic [FLAGS_W-1:0]      flags;
    logic                    last;
  } res_t;

  function automatic logic [TIMER_W-1:0] sat_add16(logic [TIMER_W-1:0] a,
                                                   logic [TIMER_W-1:0] b);
    logic [TIMER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIMER_W] ? '1 : s[TIMER_W-1:0];
  endfunction

endpackage

// ----- rtl/key_mouse_input_tracker_core.sv -----
// each accepted word ends in S_STAT, which registers a status word once the output is free
// key, button press and wheel words go straight there; button release passes S_USE first;
// move: S_SCAN per button and S_USE per held one; tick: S_SCAN per idle key, S_SCAN and S_USE per
//   held key and per button timer, all through the single port pair of the timer memory
// reset: synchronous, clears held and drag flags, position, wheel sum, config;
//   memories are not swept, button timer entries read as zero until written
`include "key_mouse_input_tracker_core_macros.svh"

module key_mouse_input_tracker_core #(
  parameter int NUM_KEYS    = kmit_pkg::NUM_KEYS_DEF,
  parameter int NUM_BUTTONS = kmit_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [kmit_pkg::FUNC_W-1:0]          func,
  input  logic [kmit_pkg::KEY_W-1:0]           key_code,
  input  logic [kmit_pkg::BTN_W-1:0]           button_index,
  input  logic signed [kmit_pkg::POS_W-1:0]    pos_x,
  input  logic signed [kmit_pkg::POS_W-1:0]    pos_y,
  input  logic signed [kmit_pkg::POS_W-1:0]    wheel_step,
  input  logic [kmit_pkg::TIMER_W-1:0]         elapsed_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [kmit_pkg::KIND_W-1:0]          kind,
  output logic [kmit_pkg::INDEX_W-1:0]         index,
  output logic signed [kmit_pkg::POS_W-1:0]    begin_x,
  output logic signed [kmit_pkg::POS_W-1:0]    begin_y,
  output logic signed [kmit_pkg::POS_W-1:0]    cur_x,
  output logic signed [kmit_pkg::POS_W-1:0]    cur_y,
  output logic signed [kmit_pkg::DELTA_W-1:0]  delta_x,
  output logic signed [kmit_pkg::DELTA_W-1:0]  delta_y,
  output logic signed [kmit_pkg::POS_W-1:0]    wheel_total,
  output logic [kmit_pkg::FLAGS_W-1:0]         flags,
  output logic                                 is_last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [kmit_pkg::CFG_AW-1:0]          paddr,
  input  logic [kmit_pkg::CFG_DW-1:0]          pwdata,
  output logic [kmit_pkg::CFG_DW-1:0]          prdata,
  output logic                                 pready
);

  import kmit_pkg::*;

  localparam int KW = NUM_KEYS > 1 ? $clog2(NUM_KEYS) : 1;
  localparam int BW = NUM_BUTTONS > 1 ? $clog2(NUM_BUTTONS) : 1;
  localparam int TD = NUM_KEYS + NUM_BUTTONS;
  localparam int TW = $clog2(TD);

  localparam logic [TW-1:0] KEY_BASE  = TW'(NUM_KEYS);
  localparam logic [TW-1:0] TICK_LAST = TW'(TD - 1);
  localparam logic [TW-1:0] MOVE_LAST = TW'(NUM_BUTTONS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_USE  = 2'd2;
  localparam logic [1:0] S_STAT = 2'd3;

  logic [1:0]            state, state_next;
  logic [TW-1:0]         ptr;
  logic [5:0]            rep_cnt;

  logic                  rep_en;
  logic [TIMER_W-1:0]    rep_delay;
  logic [TIMER_W-1:0]    click_max;

  logic [NUM_KEYS-1:0]    key_held;
  logic [NUM_BUTTONS-1:0] btn_held;
  logic [NUM_BUTTONS-1:0] btn_drag;
  logic [NUM_BUTTONS-1:0] btn_tvalid;

  logic signed [POS_W-1:0] now_x, now_y, tick_x, tick_y, wheel_sum;

  logic [FUNC_W-1:0]     op;
  logic [KEY_W-1:0]      key_q;
  logic [BTN_W-1:0]      btn_q;
  logic [TIMER_W-1:0]    el_q;
  logic signed [POS_W-1:0] old_x, old_y;
  logic                  use_old;
  logic                  rel_drag;

  logic                  acc;
  logic                  out_free;
  logic                  load;
  res_t                  res;

  logic [5:0]            key_ext, key_ext_q, btn_ext, btn_ext_q;
  logic                  key_ok_in, btn_ok_in, key_ok_q, btn_ok_q;
  logic [KW-1:0]         kin, kq, pkey;
  logic [BW-1:0]         bin, bq, pbtn, psub;
  logic [TW-1:0]         psub_full;
  logic [7:0]            ptr8;
  logic                  is_key;
  logic                  at_last;
  logic                  step;
  logic                  mark_drag;
  logic                  tv_set;
  logic                  emit;
  logic                  fire;

  logic                  t_we, t_re;
  logic [TW-1:0]         t_waddr, t_raddr;
  logic [TIMER_W-1:0]    t_wdata, t_rdata;
  logic [TIMER_W-1:0]    tval, tsum;

  logic                  d_we, d_re;
  logic [BW-1:0]         d_waddr, d_raddr;
  logic [2*POS_W-1:0]    d_wdata, d_rdata;

  logic [POS_W:0]        wsum;
  logic signed [POS_W-1:0] wsat;
  logic                  cfg_wr;

  kmit_ram #(.WIDTH(TIMER_W), .DEPTH(TD)) u_timer_ram (
    .clk  (clk),
    .we   (t_we),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .re   (t_re),
    .raddr(t_raddr),
    .rdata(t_rdata)
  );

  kmit_ram #(.WIDTH(2 * POS_W), .DEPTH(NUM_BUTTONS)) u_drag_ram (
    .clk  (clk),
    .we   (d_we),
    .waddr(d_waddr),
    .wdata(d_wdata),
    .re   (d_re),
    .raddr(d_raddr),
    .rdata(d_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign key_ext   = {1'b0, key_code};
  assign key_ok_in = key_ext < 6'(NUM_KEYS);
  assign kin       = key_ext[KW-1:0];
  assign btn_ext   = {3'b0, button_index};
  assign btn_ok_in = btn_ext < 6'(NUM_BUTTONS);
  assign bin       = btn_ext[BW-1:0];

  assign key_ext_q = {1'b0, key_q};
  assign key_ok_q  = key_ext_q < 6'(NUM_KEYS);
  assign kq        = key_ext_q[KW-1:0];
  assign btn_ext_q = {3'b0, btn_q};
  assign btn_ok_q  = btn_ext_q < 6'(NUM_BUTTONS);
  assign bq        = btn_ext_q[BW-1:0];

  assign is_key    = ptr < KEY_BASE;
  assign psub_full = ptr - KEY_BASE;
  assign psub      = psub_full[BW-1:0];
  assign pkey      = ptr[KW-1:0];
  assign pbtn      = ptr[BW-1:0];
  assign ptr8      = 8'(ptr);
  assign at_last   = (ptr == ((op == FN_TICK) ? TICK_LAST : MOVE_LAST));

  // button timers never written since reset count as zero
  always_comb begin
    if (op == FN_TICK) begin
      tval = (is_key || btn_tvalid[psub]) ? t_rdata : '0;
    end else begin
      tval = btn_tvalid[bq] ? t_rdata : '0;
    end
  end
  assign tsum = sat_add16(tval, el_q);
  assign fire = tsum >= rep_delay;

  assign wsum = {wheel_sum[POS_W-1], wheel_sum} + {wheel_step[POS_W-1], wheel_step};
  assign wsat = (wsum[POS_W] != wsum[POS_W-1]) ?
                (wsum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}}) :
                wsum[POS_W-1:0];

  always_comb begin
    state_next = state;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_re = 1'b0; t_raddr = '0;
    d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_re = 1'b0; d_raddr = '0;
    load = 1'b0;
    res = '0;
    step = 1'b0;
    mark_drag = 1'b0;
    tv_set = 1'b0;
    emit = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = S_STAT;
          unique case (func)
            FN_TICK, FN_MOVE: state_next = S_SCAN;
            FN_KPRESS: begin
              if (key_ok_in) begin
                t_we = 1'b1;
                t_waddr = TW'(kin);
              end
            end
            FN_BPRESS: begin
              if (btn_ok_in) begin
                t_we = 1'b1;
                t_waddr = KEY_BASE + TW'(bin);
              end
            end
            FN_BREL: begin
              if (btn_ok_in) begin
                state_next = S_USE;
                if (btn_drag[bin]) begin
                  d_re = 1'b1;
                  d_raddr = bin;
                end else begin
                  t_re = 1'b1;
                  t_raddr = KEY_BASE + TW'(bin);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (op == FN_TICK) begin
          if (!is_key || (rep_en && key_held[pkey])) begin
            t_re = 1'b1;
            t_raddr = ptr;
            state_next = S_USE;
          end else begin
            step = 1'b1;
            if (at_last) state_next = S_STAT;
          end
        end else begin
          if (btn_held[pbtn]) begin
            state_next = S_USE;
            if (!btn_drag[pbtn]) begin
              d_we = 1'b1;
              d_waddr = pbtn;
              d_wdata = {old_y, old_x};
              mark_drag = 1'b1;
            end else begin
              d_re = 1'b1;
              d_raddr = pbtn;
            end
          end else begin
            step = 1'b1;
            if (at_last) state_next = S_STAT;
          end
        end
      end
      S_USE: begin
        if (op == FN_TICK) begin
          res.kind = KIND_REPEAT;
          res.index = ptr8[INDEX_W-1:0];
          if (is_key) begin
            emit = fire && (rep_cnt < 6'(MAX_REPEATS));
            t_wdata = fire ? '0 : tsum;
          end else begin
            t_wdata = tsum;
          end
          if (!emit || out_free) begin
            t_we = 1'b1;
            t_waddr = ptr;
            tv_set = !is_key;
            load = emit;
            step = 1'b1;
            state_next = at_last ? S_STAT : S_SCAN;
          end
        end else if (op == FN_MOVE) begin
          res.kind = KIND_DRAG;
          res.index = ptr8[INDEX_W-1:0];
          res.begin_x = use_old ? old_x : d_rdata[POS_W-1:0];
          res.begin_y = use_old ? old_y : d_rdata[2*POS_W-1:POS_W];
          if (out_free) begin
            load = 1'b1;
            step = 1'b1;
            state_next = at_last ? S_STAT : S_SCAN;
          end
        end else begin
          res.index = {2'b0, btn_q};
          if (rel_drag) begin
            res.kind = KIND_DRAG;
            res.begin_x = d_rdata[POS_W-1:0];
            res.begin_y = d_rdata[2*POS_W-1:POS_W];
            emit = 1'b1;
          end else begin
            res.kind = KIND_CLICK;
            emit = tval <= click_max;
          end
          if (!emit || out_free) begin
            load = emit;
            state_next = S_STAT;
          end
        end
      end
      S_STAT: begin
        res.kind = KIND_STATUS;
        res.flags = {btn_ok_q && btn_drag[bq], btn_ok_q && btn_held[bq],
                     key_ok_q && key_held[kq]};
        res.last = 1'b1;
        if (out_free) begin
          load = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_REPEAT_ENABLE: prdata = CFG_DW'(rep_en);
      REG_REPEAT_DELAY:  prdata = CFG_DW'(rep_delay);
      REG_CLICK_MAX:     prdata = CFG_DW'(click_max);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ptr        <= '0;
      rep_cnt    <= '0;
      rep_en     <= 1'b0;
      rep_delay  <= REPEAT_DELAY_RST;
      click_max  <= CLICK_MAX_RST;
      key_held   <= '0;
      btn_held   <= '0;
      btn_drag   <= '0;
      btn_tvalid <= '0;
      now_x      <= '0;
      now_y      <= '0;
      tick_x     <= '0;
      tick_y     <= '0;
      wheel_sum  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_REPEAT_ENABLE: rep_en    <= pwdata[0];
          REG_REPEAT_DELAY:  rep_delay <= pwdata[TIMER_W-1:0];
          REG_CLICK_MAX:     click_max <= pwdata[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (acc) begin
        ptr     <= '0;
        rep_cnt <= '0;
        unique case (func)
          FN_TICK: begin
            wheel_sum <= '0;
            tick_x    <= now_x;
            tick_y    <= now_y;
          end
          FN_KPRESS: if (key_ok_in) key_held[kin] <= 1'b1;
          FN_KREL:   if (key_ok_in) key_held[kin] <= 1'b0;
          FN_MOVE: begin
            now_x <= pos_x;
            now_y <= pos_y;
          end
          FN_BPRESS: begin
            if (btn_ok_in) begin
              btn_held[bin]   <= 1'b1;
              btn_tvalid[bin] <= 1'b1;
            end
          end
          FN_BREL: begin
            if (btn_ok_in) begin
              btn_held[bin] <= 1'b0;
              btn_drag[bin] <= 1'b0;
            end
          end
          FN_WHEEL: wheel_sum <= wsat;
          default: ;
        endcase
      end
      if (mark_drag) btn_drag[pbtn] <= 1'b1;
      if (tv_set) btn_tvalid[psub] <= 1'b1;
      if (step) ptr <= ptr + 1'b1;
      if (load && res.kind == KIND_REPEAT) rep_cnt <= rep_cnt + 1'b1;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op       <= func;
      key_q    <= key_code;
      btn_q    <= button_index;
      el_q     <= elapsed_ms;
      old_x    <= now_x;
      old_y    <= now_y;
      rel_drag <= btn_ok_in && btn_drag[bin];
    end
    if (state == S_SCAN) begin
      use_old <= !btn_drag[pbtn];
    end
    if (load) begin
      kind        <= res.kind;
      index       <= res.index;
      begin_x     <= res.begin_x;
      begin_y     <= res.begin_y;
      cur_x       <= now_x;
      cur_y       <= now_y;
      delta_x     <= {now_x[POS_W-1], now_x} - {tick_x[POS_W-1], tick_x};
      delta_y     <= {now_y[POS_W-1], now_y} - {tick_y[POS_W-1], tick_y};
      wheel_total <= wheel_sum;
      flags       <= res.flags;
      is_last     <= res.last;
    end
  end

  `KMIT_ASSERT_NXT(a_busy_after_accept, acc, in_stall, "word taken while busy")
  `KMIT_ASSERT_NXT(a_idle_after_status, load && res.last, state == S_IDLE,
                   "not idle after status word")
  `KMIT_ASSERT_IMP(a_drag_needs_held, 1'b1, (btn_drag & ~btn_held) == '0,
                   "dragging button not held")
  `KMIT_ASSERT_IMP(a_repeat_cap, state == S_USE, rep_cnt <= 6'(MAX_REPEATS),
                   "too many repeat words")

endmodule

// ----- rtl/kmit_ram.sv -----
module kmit_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/sv/key_mouse_input_tracker_core_test.sv -----
`timescale 1ns / 1ps

module key_mouse_input_tracker_core_test;
  import kmit_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 42;
  localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [INDEX_W-1:0]       index;
    logic signed [POS_W-1:0]  begin_x;
    logic signed [POS_W-1:0]  begin_y;
    logic signed [POS_W-1:0]  cur_x;
    logic signed [POS_W-1:0]  cur_y;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [POS_W-1:0]  wheel_total;
    logic [FLAGS_W-1:0]       flags;
    logic                     is_last;
  } tracker_word_t;

  class tracker_mirror;
    bit                      rep_en;
    bit [TIMER_W-1:0]        rep_delay;
    bit [TIMER_W-1:0]        click_max;
    bit                      key_down [NUM_KEYS_DEF];
    bit [TIMER_W-1:0]        key_timer [NUM_KEYS_DEF];
    bit                      btn_down [NUM_BUTTONS_DEF];
    bit                      btn_drag [NUM_BUTTONS_DEF];
    bit [TIMER_W-1:0]        btn_timer [NUM_BUTTONS_DEF];
    bit signed [POS_W-1:0]   drag_x [NUM_BUTTONS_DEF];
    bit signed [POS_W-1:0]   drag_y [NUM_BUTTONS_DEF];
    bit signed [POS_W-1:0]   now_x, now_y, tick_x, tick_y, wheel;
    tracker_word_t           due_words[$];
    int                      errors;

    function void clear();
      rep_en = 1'b0;
      rep_delay = REPEAT_DELAY_RST;
      click_max = CLICK_MAX_RST;
      foreach (key_down[i]) begin
        key_down[i] = 1'b0;
        key_timer[i] = '0;
      end
      foreach (btn_down[i]) begin
        btn_down[i] = 1'b0;
        btn_drag[i] = 1'b0;
        btn_timer[i] = '0;
        drag_x[i] = '0;
        drag_y[i] = '0;
      end
      now_x = '0;
      now_y = '0;
      tick_x = '0;
      tick_y = '0;
      wheel = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] r, logic [CFG_DW-1:0] v);
      case (r)
        REG_REPEAT_ENABLE: rep_en = v[0];
        REG_REPEAT_DELAY: rep_delay = v[TIMER_W-1:0];
        REG_CLICK_MAX: click_max = v[TIMER_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [TIMER_W-1:0] add_clamp(bit [TIMER_W-1:0] a, bit [TIMER_W-1:0] b);
      bit [TIMER_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[TIMER_W]) return '1;
      return s[TIMER_W-1:0];
    endfunction

    function void push(logic [KIND_W-1:0] k, logic [INDEX_W-1:0] idx,
                       logic signed [POS_W-1:0] bx, logic signed [POS_W-1:0] by,
                       logic [FLAGS_W-1:0] fl, logic lst);
      tracker_word_t w;
      w.kind = k;
      w.index = idx;
      w.begin_x = bx;
      w.begin_y = by;
      w.cur_x = now_x;
      w.cur_y = now_y;
      w.delta_x = {now_x[POS_W-1], now_x} - {tick_x[POS_W-1], tick_x};
      w.delta_y = {now_y[POS_W-1], now_y} - {tick_y[POS_W-1], tick_y};
      w.wheel_total = wheel;
      w.flags = fl;
      w.is_last = lst;
      due_words.push_back(w);
    endfunction

    function void take_word(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key,
                            logic [BTN_W-1:0] btn, logic [POS_W-1:0] px,
                            logic [POS_W-1:0] py, logic [POS_W-1:0] ws,
                            logic [TIMER_W-1:0] el);
      int n;
      bit key_ok, btn_ok;
      bit signed [POS_W-1:0] ox, oy;
      logic signed [POS_W:0] s;
      logic [FLAGS_W-1:0] fl;
      n = 0;
      key_ok = key < NUM_KEYS_DEF;
      btn_ok = btn < NUM_BUTTONS_DEF;
      case (fn)
        FN_TICK: begin
          wheel = '0;
          tick_x = now_x;
          tick_y = now_y;
          if (rep_en) begin
            for (int i = 0; i < NUM_KEYS_DEF; i++) begin
              if (key_down[i]) begin
                key_timer[i] = add_clamp(key_timer[i], el);
                if (key_timer[i] >= rep_delay) begin
                  key_timer[i] = '0;
                  if (n < MAX_REPEATS) begin
                    push(KIND_REPEAT, INDEX_W'(i), '0, '0, '0, 1'b0);
                    n++;
                  end
                end
              end
            end
          end
          foreach (btn_timer[i]) btn_timer[i] = add_clamp(btn_timer[i], el);
        end
        FN_KPRESS: begin
          if (key_ok) begin
            key_down[key] = 1'b1;
            key_timer[key] = '0;
          end
        end
        FN_KREL: begin
          if (key_ok) key_down[key] = 1'b0;
        end
        FN_MOVE: begin
          ox = now_x;
          oy = now_y;
          now_x = px;
          now_y = py;
          for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
            if (btn_down[i]) begin
              if (!btn_drag[i]) begin
                btn_drag[i] = 1'b1;
                drag_x[i] = ox;
                drag_y[i] = oy;
              end
              push(KIND_DRAG, INDEX_W'(i), drag_x[i], drag_y[i], '0, 1'b0);
            end
          end
        end
        FN_BPRESS: begin
          if (btn_ok) begin
            btn_down[btn] = 1'b1;
            btn_timer[btn] = '0;
          end
        end
        FN_BREL: begin
          if (btn_ok) begin
            btn_down[btn] = 1'b0;
            if (btn_drag[btn]) begin
              btn_drag[btn] = 1'b0;
              push(KIND_DRAG, INDEX_W'(btn), drag_x[btn], drag_y[btn], '0, 1'b0);
            end else if (btn_timer[btn] <= click_max) begin
              push(KIND_CLICK, INDEX_W'(btn), '0, '0, '0, 1'b0);
            end
          end
        end
        FN_WHEEL: begin
          s = $signed({wheel[POS_W-1], wheel}) + $signed({ws[POS_W-1], ws});
          if (s > 17'sd32767) s = 17'sd32767;
          if (s < -17'sd32768) s = -17'sd32768;
          wheel = s[POS_W-1:0];
        end
        default: ;
      endcase
      fl = '0;
      if (key_ok && key_down[key]) fl[0] = 1'b1;
      if (btn_ok && btn_down[btn]) fl[1] = 1'b1;
      if (btn_ok && btn_drag[btn]) fl[2] = 1'b1;
      push(KIND_STATUS, '0, '0, '0, fl, 1'b1);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task field(string name, logic [DELTA_W-1:0] got, logic [DELTA_W-1:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task match_word(tracker_word_t got);
      tracker_word_t want;
      if (due_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d index %0d", got.kind, got.index));
      end else begin
        want = due_words.pop_front();
        field("kind", DELTA_W'(got.kind), DELTA_W'(want.kind));
        field("index", DELTA_W'(got.index), DELTA_W'(want.index));
        field("begin_x", DELTA_W'(got.begin_x), DELTA_W'(want.begin_x));
        field("begin_y", DELTA_W'(got.begin_y), DELTA_W'(want.begin_y));
        field("cur_x", DELTA_W'(got.cur_x), DELTA_W'(want.cur_x));
        field("cur_y", DELTA_W'(got.cur_y), DELTA_W'(want.cur_y));
        field("delta_x", got.delta_x, want.delta_x);
        field("delta_y", got.delta_y, want.delta_y);
        field("wheel_total", DELTA_W'(got.wheel_total), DELTA_W'(want.wheel_total));
        field("flags", DELTA_W'(got.flags), DELTA_W'(want.flags));
        field("is_last", DELTA_W'(got.is_last), DELTA_W'(want.is_last));
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [FUNC_W-1:0]         func = '0;
  logic [KEY_W-1:0]          key_code = '0;
  logic [BTN_W-1:0]          button_index = '0;
  logic signed [POS_W-1:0]   pos_x = '0;
  logic signed [POS_W-1:0]   pos_y = '0;
  logic signed [POS_W-1:0]   wheel_step = '0;
  logic [TIMER_W-1:0]        elapsed_ms = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [KIND_W-1:0]         kind;
  logic [INDEX_W-1:0]        index;
  logic signed [POS_W-1:0]   begin_x;
  logic signed [POS_W-1:0]   begin_y;
  logic signed [POS_W-1:0]   cur_x;
  logic signed [POS_W-1:0]   cur_y;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic signed [POS_W-1:0]   wheel_total;
  logic [FLAGS_W-1:0]        flags;
  logic                      is_last;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CFG_AW-1:0]         paddr = '0;
  logic [CFG_DW-1:0]         pwdata = '0;
  logic [CFG_DW-1:0]         prdata;
  logic                      pready;

  tracker_mirror sb = new();
  int            idle_mode = 0;
  int            quiet_cycles = 0;
  tracker_word_t seen;

  key_mouse_input_tracker_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .key_code(key_code), .button_index(button_index),
    .pos_x(pos_x), .pos_y(pos_y), .wheel_step(wheel_step), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .index(index), .begin_x(begin_x), .begin_y(begin_y),
    .cur_x(cur_x), .cur_y(cur_y), .delta_x(delta_x), .delta_y(delta_y),
    .wheel_total(wheel_total), .flags(flags), .is_last(is_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int send_idle_pct();
    return idle_mode == 0 ? 27 : (idle_mode == 1 ? 55 : 0);
  endfunction

  function automatic int recv_idle_pct();
    return idle_mode == 0 ? 55 : (idle_mode == 1 ? 27 : 0);
  endfunction

  // result side: check accepted words, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.kind = kind;
      seen.index = index;
      seen.begin_x = begin_x;
      seen.begin_y = begin_y;
      seen.cur_x = cur_x;
      seen.cur_y = cur_y;
      seen.delta_x = delta_x;
      seen.delta_y = delta_y;
      seen.wheel_total = wheel_total;
      seen.flags = flags;
      seen.is_last = is_last;
      sb.match_word(seen);
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("key_mouse_input_tracker_core_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_word(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key, logic [BTN_W-1:0] btn,
                 logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [POS_W-1:0] ws,
                 logic [TIMER_W-1:0] el);
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    key_code <= key;
    button_index <= btn;
    pos_x <= px;
    pos_y <= py;
    wheel_step <= ws;
    elapsed_ms <= el;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_word(fn, key, btn, px, py, ws, el);
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task apb_write(logic [1:0] r, logic [CFG_DW-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(r, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task program_regs(logic en, logic [TIMER_W-1:0] delay, logic [TIMER_W-1:0] cmax);
    wait_idle();
    apb_write(REG_REPEAT_ENABLE, {31'd0, en});
    apb_write(REG_REPEAT_DELAY, {16'd0, delay});
    apb_write(REG_CLICK_MAX, {16'd0, cmax});
    @(posedge clk);
  endtask

  // directed op with noise in the fields it ignores
  task op(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key, logic [BTN_W-1:0] btn,
          logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [POS_W-1:0] ws,
          logic [TIMER_W-1:0] el);
    send_word(fn, key, btn, px, py, ws, el);
  endtask

  task random_word();
    logic [FUNC_W-1:0]  fn;
    logic [TIMER_W-1:0] el;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 18) fn = FN_TICK;
    else if (r < 32) fn = FN_KPRESS;
    else if (r < 42) fn = FN_KREL;
    else if (r < 62) fn = FN_MOVE;
    else if (r < 74) fn = FN_BPRESS;
    else if (r < 86) fn = FN_BREL;
    else if (r < 96) fn = FN_WHEEL;
    else fn = FN_SPARE;
    case ($urandom_range(0, 9))
      0: el = '0;
      1: el = TIMER_W'($urandom_range(0, 65535));
      2: el = '1;
      default: el = TIMER_W'($urandom_range(0, 300));
    endcase
    send_word(fn, KEY_W'($urandom_range(0, 31)), BTN_W'($urandom_range(0, 7)),
              POS_W'($urandom_range(0, 65535)), POS_W'($urandom_range(0, 65535)),
              POS_W'($urandom_range(0, 65535)), el);
  endtask

  initial begin
    sb.clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default registers: wheel and position extremes, clicks, drags
    op(FN_WHEEL, 5'd3, 3'd1, 16'h1234, 16'h4321, 16'sh7fff, 16'd0);
    op(FN_WHEEL, 5'd3, 3'd1, 16'h0, 16'h0, 16'sh7fff, 16'd0);
    op(FN_BREL, 5'd0, 3'd6, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_TICK, 5'd0, 3'd0, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_WHEEL, 5'd0, 3'd0, 16'h0, 16'h0, 16'sh8000, 16'd0);
    op(FN_WHEEL, 5'd0, 3'd0, 16'h0, 16'h0, 16'sh8000, 16'd0);
    op(FN_MOVE, 5'd0, 3'd0, 16'sh8000, 16'sh7fff, 16'h0, 16'd0);
    op(FN_TICK, 5'd0, 3'd0, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_MOVE, 5'd0, 3'd0, 16'sh7fff, 16'sh8000, 16'h0, 16'd0);
    op(FN_BPRESS, 5'd0, 3'd7, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_BREL, 5'd0, 3'd7, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_BPRESS, 5'd0, 3'd0, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_TICK, 5'd0, 3'd0, 16'h0, 16'h0, 16'h0, 16'd300);
    op(FN_BREL, 5'd0, 3'd0, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_BPRESS, 5'd0, 3'd1, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_BPRESS, 5'd0, 3'd2, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_MOVE, 5'd0, 3'd1, 16'd100, 16'd200, 16'h0, 16'd0);
    op(FN_MOVE, 5'd0, 3'd2, 16'hfffb, 16'd7, 16'h0, 16'd0);
    op(FN_BREL, 5'd0, 3'd1, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_BREL, 5'd0, 3'd2, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_KPRESS, 5'd31, 3'd0, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_KPRESS, 5'd0, 3'd0, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_SPARE, 5'd31, 3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

    // zero delay fires on every tick
    program_regs(1'b1, 16'd0, 16'hffff);
    op(FN_TICK, 5'd31, 3'd0, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_KREL, 5'd31, 3'd0, 16'h0, 16'h0, 16'h0, 16'd0);

    // longest delay, saturating timers
    program_regs(1'b1, 16'hffff, 16'hffff);
    op(FN_BPRESS, 5'd0, 3'd4, 16'h0, 16'h0, 16'h0, 16'd0);
    op(FN_TICK, 5'd0, 3'd4, 16'h0, 16'h0, 16'h0, 16'd40000);
    op(FN_TICK, 5'd0, 3'd4, 16'h0, 16'h0, 16'h0, 16'd40000);
    op(FN_BREL, 5'd0, 3'd4, 16'h0, 16'h0, 16'h0, 16'd0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_regs(1'b1, TIMER_W'($urandom_range(50, 400)),
                        TIMER_W'($urandom_range(50, 300)));
        1: program_regs(1'b1, 16'hffff, 16'd0);
        2: program_regs(1'b1, 16'd0, 16'hffff);
        3: program_regs(1'b0, TIMER_W'($urandom_range(1, 65535)),
                        TIMER_W'($urandom_range(0, 65535)));
        4: program_regs(1'b1, 16'd1, TIMER_W'($urandom_range(0, 65535)));
        default: program_regs(1'b1, TIMER_W'($urandom_range(20, 200)),
                              TIMER_W'($urandom_range(0, 400)));
      endcase
      idle_mode = p / 2;
      repeat (PHASE_ITEMS) random_word();
    end

    wait_idle();
    if (sb.errors == 0 && sb.due_words.size() == 0) begin
      $display("key_mouse_input_tracker_core_test passed");
    end else begin
      $display("key_mouse_input_tracker_core_test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/kmit_pkg.sv
rtl/kmit_ram.sv
rtl/key_mouse_input_tracker_core.sv
tb/sv/key_mouse_input_tracker_core_test.sv
